// File: rtl/core/ae_pkg.sv
// Shared constants and controller/datapath interface types for the arithmetic encoder.
package ae_pkg;

    localparam int DefPrecisionBits = 28;
    localparam int DefCountBits     = 16;

    // Renormalization limits per encode word
    localparam int LoopCap   = 64;
    localparam int ResultCap = 28;
    localparam int LoopW     = 7;
    localparam int ResultW   = 5;

    // Fixed field widths of the stream words
    localparam int CumLowW    = 16;
    localparam int CumHighW   = 17;
    localparam int FollowW    = 16;
    localparam int InDataW    = 56;
    localparam int OutDataW   = 24;

    typedef struct packed {
        logic load;          // capture an accepted input word
        logic mul_hi;        // span * cum_high into the upper divider
        logic mul_lo;        // span * cum_low into the lower divider
        logic div_step;      // one quotient bit on both dividers
        logic update;        // narrow the range from the quotients
        logic renorm_step;   // one renormalization iteration
        logic release_last;  // move the held result out, marked last
        logic flush;         // final bit and return to reset values
    } ae_cmd_t;

    typedef struct packed {
        logic in_op;         // opcode of the word on the input port
        logic in_ok;         // interval on the input port is usable
        logic emit;          // this iteration emits a bit
        logic mid;           // this iteration expands about the middle
        logic hold_vld;      // a result waits in the hold register
        logic out_free;      // output register can take a word this cycle
    } ae_stat_t;

endpackage

// File: rtl/core/arithmetic_encoder_core.sv
// Top level of the integer arithmetic encoder: stream ports, controller and datapath.
//
//  Port group   Dir   Carries
//  s_*          in    one encode or flush word (cum_low, cum_high, total_count; opcode)
//  m_*          out   one emitted code bit with its follow count, tlast on the last one
//
//  Sequence: an encode word passes from the idle state that takes it through the two
//  multiply states, the serial divider steps, the range update and the renormalization
//  state, which runs the renormalization iterations and closes when none is left. A
//  flush passes through the flush state; a rejected interval is taken and dropped in
//  the idle state.
//  Reset: aresetn low for one clock sets the range to [0, 2^PRECISION_BITS), clears
//  the pending count and drops any word in the output register.
//  Stalls: while m_tready is low, renormalization halts at an emission that finds both
//  the output register and the hold slot full; input is taken again as soon as the
//  last result sits in the output register.
module arithmetic_encoder_core #(
    parameter int PRECISION_BITS = ae_pkg::DefPrecisionBits,
    parameter int COUNT_BITS     = ae_pkg::DefCountBits
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] cum_low, [32:16] cum_high, [49:33] total_count, [55:50] zero
    input  logic [ae_pkg::InDataW-1:0]    s_tdata,
    // [0] opcode: 0 encode, 1 flush
    input  logic                          s_tuser,
    // Result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] emitted_bit, [16:1] follow_count, [23:17] zero
    output logic [ae_pkg::OutDataW-1:0]   m_tdata,
    output logic                          m_tlast
);
    import ae_pkg::*;

    // Commands from the sequencer, status back from the datapath
    ae_cmd_t  cmd;
    ae_stat_t st;

    // Sequencer: idle, multiply, divide, update, renormalize, flush
    ae_ctrl #(
        .PRECISION_BITS (PRECISION_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath: range registers, scaling, renormalization and output register
    ae_dp #(
        .PRECISION_BITS (PRECISION_BITS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

// File: rtl/core/ae_div.sv
// Restoring divider, one quotient bit per cycle while step is high, for the range scaling.
module ae_div #(
    parameter int PRECISION_BITS = ae_pkg::DefPrecisionBits
) (
    input  logic                        aclk,
    input  logic                        load,
    input  logic                        step,
    input  logic [PRECISION_BITS+17:0]  dividend,
    input  logic [16:0]                 divisor,
    output logic [PRECISION_BITS:0]     quotient
);
    import ae_pkg::*;

    localparam int P = PRECISION_BITS;

    logic [16:0] rem_reg, rem_next;
    logic [P:0]  q_reg, q_next;
    logic [17:0] trial;
    logic [17:0] diff;
    logic        ge;

    // Upper bits of the dividend are known to stay below the divisor.
    always_comb begin
        trial    = {rem_reg, q_reg[P]};
        ge       = trial >= {1'b0, divisor};
        diff     = trial - {1'b0, divisor};
        rem_next = ge ? diff[16:0] : trial[16:0];
        q_next   = {q_reg[P-1:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= dividend[P+17:P+1];
            q_reg   <= dividend[P:0];
        end else if (step) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign quotient = q_reg;

endmodule

// File: rtl/core/ae_ctrl.sv
// Sequencing state machine for the arithmetic encoder.
module ae_ctrl #(
    parameter int PRECISION_BITS = ae_pkg::DefPrecisionBits
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  ae_pkg::ae_stat_t st,
    output ae_pkg::ae_cmd_t  cmd
);
    import ae_pkg::*;

    localparam int P    = PRECISION_BITS;
    localparam int DivW = $clog2(P + 1);

    localparam logic [2:0] StIdle   = 3'd0;
    localparam logic [2:0] StMulHi  = 3'd1;
    localparam logic [2:0] StMulLo  = 3'd2;
    localparam logic [2:0] StDiv    = 3'd3;
    localparam logic [2:0] StUpdate = 3'd4;
    localparam logic [2:0] StRenorm = 3'd5;
    localparam logic [2:0] StFlush  = 3'd6;

    logic [2:0]      state_reg, state_next;
    logic [DivW-1:0] div_cnt_reg, div_cnt_next;

    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            StIdle: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    if (st.in_op) begin
                        state_next = StFlush;
                    end else if (st.in_ok) begin
                        state_next = StMulHi;
                    end
                end
            end
            StMulHi: begin
                cmd.mul_hi = 1'b1;
                state_next = StMulLo;
            end
            StMulLo: begin
                cmd.mul_lo   = 1'b1;
                div_cnt_next = '0;
                state_next   = StDiv;
            end
            StDiv: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DivW'(P)) begin
                    state_next = StUpdate;
                end
            end
            StUpdate: begin
                cmd.update = 1'b1;
                state_next = StRenorm;
            end
            StRenorm: begin
                if (st.emit) begin
                    // stall while an earlier result cannot leave the hold slot
                    cmd.renorm_step = !st.hold_vld || st.out_free;
                end else if (st.mid) begin
                    cmd.renorm_step = 1'b1;
                end else if (st.hold_vld) begin
                    if (st.out_free) begin
                        cmd.release_last = 1'b1;
                        state_next       = StIdle;
                    end
                end else begin
                    state_next = StIdle;
                end
            end
            StFlush: begin
                if (st.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = StIdle;
                end
            end
            default: begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= StIdle;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    assign s_tready = (state_reg == StIdle);

endmodule

// File: rtl/core/ae_dp.sv
// Range, pending count, scaling and renormalization datapath of the encoder.
module ae_dp #(
    parameter int PRECISION_BITS = ae_pkg::DefPrecisionBits,
    parameter int COUNT_BITS     = ae_pkg::DefCountBits
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ae_pkg::InDataW-1:0]    s_tdata,
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ae_pkg::OutDataW-1:0]   m_tdata,
    output logic                          m_tlast,
    input  ae_pkg::ae_cmd_t               cmd,
    output ae_pkg::ae_stat_t              st
);
    import ae_pkg::*;

    localparam int P = PRECISION_BITS;
    localparam int C = COUNT_BITS;

    localparam logic [P:0]  CodeMax   = (P+1)'(1) << P;
    localparam logic [P:0]  Half      = (P+1)'(1) << (P - 1);
    localparam logic [P:0]  Quarter   = (P+1)'(1) << (P - 2);
    localparam logic [P:0]  ThreeQ    = Half + Quarter;
    localparam logic [16:0] CountLim  = 17'(1) << C;

    // Input word fields
    logic [15:0] in_lo;
    logic [16:0] in_hi;
    logic [16:0] in_tot;

    assign in_lo  = s_tdata[15:0];
    assign in_hi  = s_tdata[32:16];
    assign in_tot = s_tdata[49:33];

    logic [15:0]        op_lo_reg;
    logic [16:0]        op_hi_reg;
    logic [16:0]        op_tot_reg;
    logic [P-1:0]       low_reg;
    logic [P:0]         high_reg;
    logic [C-1:0]       pend_reg;
    logic [LoopW-1:0]   iter_reg;
    logic [ResultW-1:0] emit_cnt_reg;
    logic               hold_vld_reg;
    logic               hold_bit_reg;
    logic [C-1:0]       hold_cnt_reg;
    logic               out_vld_reg;
    logic               out_bit_reg;
    logic [C-1:0]       out_cnt_reg;
    logic               out_last_reg;

    logic [P:0]    span;
    logic [16:0]   mul_op;
    logic [P+17:0] mul_prod;
    logic [P:0]    q_hi;
    logic [P:0]    q_lo;
    logic [P:0]    low_ext;
    logic          below_half;
    logic          upper_half;
    logic          middle;
    logic          capped;
    logic          emit_bit;
    logic [P:0]    sub;
    logic [P:0]    low_next;
    logic [P:0]    high_next;
    logic [C-1:0]  pend_sat;
    logic          out_free;
    logic          push_hold;

    // Scaling multiply, registered inside the dividers
    assign span     = high_reg - {1'b0, low_reg};
    assign mul_op   = cmd.mul_hi ? op_hi_reg : {1'b0, op_lo_reg};
    assign mul_prod = {17'd0, span} * {{(P+1){1'b0}}, mul_op};

    ae_div #(.PRECISION_BITS(P)) u_div_hi (
        .aclk     (aclk),
        .load     (cmd.mul_hi),
        .step     (cmd.div_step),
        .dividend (mul_prod),
        .divisor  (op_tot_reg),
        .quotient (q_hi)
    );

    ae_div #(.PRECISION_BITS(P)) u_div_lo (
        .aclk     (aclk),
        .load     (cmd.mul_lo),
        .step     (cmd.div_step),
        .dividend (mul_prod),
        .divisor  (op_tot_reg),
        .quotient (q_lo)
    );

    // Renormalization decision
    always_comb begin
        low_ext    = {1'b0, low_reg};
        below_half = high_reg < Half;
        upper_half = low_ext >= Half;
        middle     = (low_ext > Quarter) && (high_reg < ThreeQ);
        capped     = (iter_reg == LoopW'(LoopCap)) || (emit_cnt_reg == ResultW'(ResultCap));
        emit_bit   = !below_half;
        if (below_half) begin
            sub = '0;
        end else if (upper_half) begin
            sub = Half;
        end else begin
            sub = Quarter;
        end
        low_next  = (low_ext - sub) << 1;
        high_next = (high_reg - sub) << 1;
        pend_sat  = (pend_reg == {C{1'b1}}) ? pend_reg : pend_reg + 1'b1;
    end

    assign out_free  = !out_vld_reg || m_tready;
    assign push_hold = cmd.renorm_step && st.emit && hold_vld_reg;

    always_comb begin
        st.in_op    = s_tuser;
        st.in_ok    = (in_tot != 17'd0) && (in_tot <= CountLim) &&
                      ({1'b0, in_lo} < in_hi) && (in_hi <= in_tot);
        st.emit     = !capped && (below_half || upper_half);
        st.mid      = !capped && !(below_half || upper_half) && middle;
        st.hold_vld = hold_vld_reg;
        st.out_free = out_free;
    end

    // Input operand capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_lo_reg  <= in_lo;
            op_hi_reg  <= in_hi;
            op_tot_reg <= in_tot;
        end
    end

    // Coding state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.flush) begin
            low_reg  <= '0;
            high_reg <= CodeMax;
            pend_reg <= '0;
        end else if (cmd.update) begin
            high_reg <= low_ext + q_hi;
            low_reg  <= P'(low_ext + q_lo);
        end else if (cmd.renorm_step) begin
            low_reg  <= low_next[P-1:0];
            high_reg <= high_next;
            if (st.emit) begin
                pend_reg <= '0;
            end else begin
                pend_reg <= pend_sat;
            end
        end
    end

    // Iteration and emission counters
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load) begin
            iter_reg     <= '0;
            emit_cnt_reg <= '0;
        end else if (cmd.renorm_step) begin
            iter_reg <= iter_reg + 1'b1;
            if (st.emit) begin
                emit_cnt_reg <= emit_cnt_reg + 1'b1;
            end
        end
    end

    // Hold the newest result until it is known whether it is the last one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
        end else if (cmd.renorm_step && st.emit) begin
            hold_vld_reg <= 1'b1;
        end else if (cmd.release_last) begin
            hold_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.renorm_step && st.emit) begin
            hold_bit_reg <= emit_bit;
            hold_cnt_reg <= pend_reg;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.flush || cmd.release_last || push_hold) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.flush) begin
            out_bit_reg  <= !(low_ext < Quarter);
            out_cnt_reg  <= pend_sat;
            out_last_reg <= 1'b1;
        end else if (cmd.release_last || push_hold) begin
            out_bit_reg  <= hold_bit_reg;
            out_cnt_reg  <= hold_cnt_reg;
            out_last_reg <= cmd.release_last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, FollowW'(out_cnt_reg), out_bit_reg};
    assign m_tlast  = out_last_reg;

    a_range_order: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, low_reg} <= high_reg)
        else $error("range low above range high");

    a_range_top: assert property (@(posedge aclk) disable iff (!aresetn)
        high_reg <= CodeMax)
        else $error("range high beyond code maximum");

    a_hold_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_vld_reg |-> (emit_cnt_reg != '0))
        else $error("held result without a counted emission");

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.flush || cmd.release_last || push_hold) |-> out_free)
        else $error("output register overwritten while full");

    a_caps: assert property (@(posedge aclk) disable iff (!aresetn)
        (iter_reg <= LoopW'(LoopCap)) && (emit_cnt_reg <= ResultW'(ResultCap)))
        else $error("renormalization counters beyond their limits");

endmodule
